// ===== hdl/nqp_pkg.sv =====
`default_nettype none
package nqp_pkg;

  localparam int CORNERS = 4;
  localparam int COORD_W = 16;
  localparam int DEPTH_W = 24;
  localparam int TAG_W   = 16;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_PICK  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef struct packed {
    logic [CORNERS-1:0][COORD_W-1:0] xs;
    logic [CORNERS-1:0][COORD_W-1:0] ys;
    logic [DEPTH_W-1:0]              depth;
    logic [TAG_W-1:0]                tag;
  } quad_t;

  typedef struct packed {
    logic               valid;
    logic               contained;
    logic [DEPTH_W-1:0] depth;
    logic [TAG_W-1:0]   tag;
  } test_res_t;

endpackage
`default_nettype wire

// ===== hdl/nqp_cell.sv =====
`default_nettype none
module nqp_cell (
  input  wire logic          clk,
  input  wire logic          load_en,
  input  wire nqp_pkg::quad_t load_quad,
  input  wire logic          shift_en,
  input  wire nqp_pkg::quad_t shift_in,
  output nqp_pkg::quad_t      quad_q
);
  import nqp_pkg::*;

  quad_t quad_r;

  always_ff @(posedge clk) begin
    if (load_en) begin
      quad_r <= load_quad;
    end else if (shift_en) begin
      quad_r <= shift_in;
    end
  end

  assign quad_q = quad_r;

endmodule
`default_nettype wire

// ===== hdl/nqp_test.sv =====
`default_nettype none
module nqp_test #(
  parameter int PW = 18
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 feed_valid,
  input  wire nqp_pkg::quad_t       quad,
  input  wire logic signed [PW-1:0] px,
  input  wire logic signed [PW-1:0] py,
  output nqp_pkg::test_res_t        res,
  output logic                      busy
);
  import nqp_pkg::*;

  localparam int AW = PW + 1;
  localparam int DW = COORD_W + 1;
  localparam int MW = AW + DW;

  logic                     v1_r, v2_r, v3_r;
  logic [CORNERS-1:0]       cond1_r, dpos1_r, cond2_r, dpos2_r;
  logic signed [AW-1:0]     a1_r [CORNERS];
  logic signed [DW-1:0]     d1_r [CORNERS];
  logic signed [DW-1:0]     e1_r [CORNERS];
  logic signed [AW-1:0]     f1_r [CORNERS];
  logic signed [MW-1:0]     lhs2_r [CORNERS];
  logic signed [MW-1:0]     rhs2_r [CORNERS];
  logic [DEPTH_W-1:0]       depth1_r, depth2_r, depth3_r;
  logic [TAG_W-1:0]         tag1_r, tag2_r, tag3_r;
  logic                     inside3_r;
  logic                     inside_nxt;

  always_ff @(posedge clk) begin
    for (int a = 0; a < CORNERS; a++) begin
      logic signed [AW-1:0] xa, ya, xb, yb;
      xa = AW'(signed'(quad.xs[a]));
      ya = AW'(signed'(quad.ys[a]));
      xb = AW'(signed'(quad.xs[(a + CORNERS - 1) % CORNERS]));
      yb = AW'(signed'(quad.ys[(a + CORNERS - 1) % CORNERS]));
      cond1_r[a] <= (ya > AW'(py)) != (yb > AW'(py));
      dpos1_r[a] <= yb > ya;
      a1_r[a]    <= AW'(px) - xa;
      d1_r[a]    <= DW'(yb - ya);
      e1_r[a]    <= DW'(xb - xa);
      f1_r[a]    <= AW'(py) - ya;
    end
    depth1_r <= quad.depth;
    tag1_r   <= quad.tag;
    for (int a = 0; a < CORNERS; a++) begin
      lhs2_r[a] <= MW'(a1_r[a]) * MW'(d1_r[a]);
      rhs2_r[a] <= MW'(e1_r[a]) * MW'(f1_r[a]);
    end
    cond2_r  <= cond1_r;
    dpos2_r  <= dpos1_r;
    depth2_r <= depth1_r;
    tag2_r   <= tag1_r;
    inside3_r <= inside_nxt;
    depth3_r  <= depth2_r;
    tag3_r    <= tag2_r;
  end

  always_comb begin
    inside_nxt = 1'b0;
    for (int a = 0; a < CORNERS; a++) begin
      if (cond2_r[a] && (dpos2_r[a] ? (lhs2_r[a] < rhs2_r[a]) : (lhs2_r[a] > rhs2_r[a]))) begin
        inside_nxt = ~inside_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= feed_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign res.valid     = v3_r;
  assign res.contained = inside3_r;
  assign res.depth     = depth3_r;
  assign res.tag       = tag3_r;
  assign busy          = v1_r | v2_r | v3_r;

endmodule
`default_nettype wire

// ===== hdl/nearest_quad_pick.sv =====
// nearest_quad_pick: depth-sorted hit test over a table of screen quads.
// Input stream: in_tuser carries the request kind (load, clear, pick), in_tdata
// the corners, depth and tag. Load and clear words are taken back to back while
// idle and give no output word. A pick word scales its point by SUPERSAMPLE and
// tests it against every stored quad; one output word follows with the hit
// flag in out_tuser and the tag of the nearest containing quad in out_tdata.
// The quads sit in a ring of MAX_QUADS cells that rotates once per pick,
// feeding one quad per cycle into a three-stage crossing test at its head.
// The ring first rotates through all MAX_QUADS cells, then the crossing test
// drains, and the result enters the output register once it is free. in_tready
// is low from the pick until its result has entered the output register.
// The result waits in an output register; loads and clears are still taken
// while it is held, but a further pick cannot finish until it is taken.
// Reset empties the table and drops any pending result; stored quad contents
// are not cleared. Loads into a full table are dropped.
`default_nettype none
module nearest_quad_pick #(
  parameter int MAX_QUADS   = 256,
  parameter int SUPERSAMPLE = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
  // corner3_x, corner3_y, face_depth_in, face_tag_in
  input  wire logic [167:0] in_tdata,
  // req_type
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // hit_tag
  output logic [15:0]       out_tdata,
  // hit
  output logic              out_tuser
);
  import nqp_pkg::*;

  localparam int CW = $clog2(MAX_QUADS + 1);
  localparam int PW = COORD_W + 1 + $clog2(SUPERSAMPLE);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] step_r, step_nxt;
  logic signed [PW-1:0] px_r, py_r;
  logic found_r, found_nxt;
  logic [DEPTH_W-1:0] best_depth_r, best_depth_nxt;
  logic [TAG_W-1:0] best_tag_r, best_tag_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_hit_r;
  logic [TAG_W-1:0] out_tag_r;

  quad_t in_quad;
  quad_t ring [MAX_QUADS];
  logic in_acc, is_load, is_pick, shift_en, test_busy;
  test_res_t res;

  assign in_acc  = in_tvalid && in_tready;
  assign is_load = in_acc && (req_t'(in_tuser) == REQ_LOAD) && (count_r < CW'(MAX_QUADS));
  assign is_pick = in_acc && (req_t'(in_tuser) == REQ_PICK);
  assign shift_en = (state_r == S_SCAN);
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    for (int k = 0; k < CORNERS; k++) begin
      in_quad.xs[k] = in_tdata[32*k +: COORD_W];
      in_quad.ys[k] = in_tdata[32*k + COORD_W +: COORD_W];
    end
    in_quad.depth = in_tdata[128 +: DEPTH_W];
    in_quad.tag   = in_tdata[152 +: TAG_W];
  end

  for (genvar i = 0; i < MAX_QUADS; i++) begin : g_ring
    nqp_cell u_cell (
      .clk      (clk),
      .load_en  (is_load && (count_r == CW'(i))),
      .load_quad(in_quad),
      .shift_en (shift_en),
      .shift_in (ring[(i + 1) % MAX_QUADS]),
      .quad_q   (ring[i])
    );
  end

  nqp_test #(.PW(PW)) u_test (
    .clk       (clk),
    .rst_n     (rst_n),
    .feed_valid(shift_en && (step_r < count_r)),
    .quad      (ring[0]),
    .px        (px_r),
    .py        (py_r),
    .res       (res),
    .busy      (test_busy)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    step_nxt       = step_r;
    found_nxt      = found_r;
    best_depth_nxt = best_depth_r;
    best_tag_nxt   = best_tag_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    if (res.valid && res.contained && (!found_r || res.depth < best_depth_r)) begin
      found_nxt      = 1'b1;
      best_depth_nxt = res.depth;
      best_tag_nxt   = res.tag;
    end
    unique case (state_r)
      S_IDLE: begin
        if (is_load) begin
          count_nxt = count_r + 1'b1;
        end
        if (in_acc && (req_t'(in_tuser) == REQ_CLEAR)) begin
          count_nxt = '0;
        end
        if (is_pick) begin
          state_nxt = S_SCAN;
          step_nxt  = '0;
          found_nxt = 1'b0;
        end
      end
      S_SCAN: begin
        step_nxt = step_r + 1'b1;
        if (step_r == CW'(MAX_QUADS - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!test_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r       <= step_nxt;
    best_depth_r <= best_depth_nxt;
    best_tag_r   <= best_tag_nxt;
    if (is_pick) begin
      px_r <= PW'(signed'(in_tdata[15:0])) * PW'(SUPERSAMPLE);
      py_r <= PW'(signed'(in_tdata[31:16])) * PW'(SUPERSAMPLE);
    end
    if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_hit_r <= found_r;
      out_tag_r <= found_r ? best_tag_r : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tag_r;
  assign out_tuser  = out_hit_r;

endmodule
`default_nettype wire

// ===== hdl/nqp_checker.sv =====
`default_nettype none
module nqp_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic [1:0]   in_tuser,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [15:0]  out_tdata,
  input wire logic         out_tuser
);
  import nqp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 16'd0)
    else $error("miss word carries a tag");

  a_pick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == REQ_PICK) |=> !in_tready)
    else $error("input taken during scan");

endmodule

bind nearest_quad_pick nqp_checker u_nqp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
`default_nettype wire
